FILE: rtl/ptwq_pkg.sv
// ----------------------------------------------------------------------------
// Peak table window query package
// Opcodes, status codes and limits shared by the peak table block.
// ----------------------------------------------------------------------------
`default_nettype none
package ptwq_pkg;
   localparam int DEFAULT_TABLE_DEPTH = 4096;

   localparam logic [2:0] OP_CLEAR    = 3'd0;
   localparam logic [2:0] OP_ADD      = 3'd1;
   localparam logic [2:0] OP_SUM_ABS  = 3'd2;
   localparam logic [2:0] OP_SUM_PPM  = 3'd3;
   localparam logic [2:0] OP_MAX_ABS  = 3'd4;
   localparam logic [2:0] OP_MAX_PPM  = 3'd5;
   localparam logic [2:0] OP_NEAR_ABS = 3'd6;
   localparam logic [2:0] OP_NEAR_PPM = 3'd7;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NONE     = 2'd2;

   localparam logic [43:0] SUM_LIMIT  = 44'hFFF_FFFF_FFFF;
   localparam logic [31:0] MASS_LIMIT = 32'hFFFF_FFFF;
   localparam logic [19:0] PPM_SCALE  = 20'd1000000;
endpackage
`default_nettype wire

FILE: rtl/peak_table_window_query.sv
// ----------------------------------------------------------------------------
// Peak table window query
// Mass-sorted peak table with add, clear and windowed sum, max and nearest
// queries, run by a small sequencer around one memory port.
// ----------------------------------------------------------------------------
// Channel  | Ports                                   | Handshake
// request  | req_opcode/query_mass/upper_mass/...    | start and not busy
// response | rsp_status/intensity_total/found_...    | done strobe, one cycle
//
// Steps: a ppm window first runs a serial multiply, then a reciprocal multiply
// and correction for the division by one million, and then forms the bounds; a
// binary search reads and checks once per halving on the single memory port; a
// window walk reads and checks each peak inside the window; an insertion shifts
// the upper part of the table one entry at a time, a read and then a write per
// entry. Accept, dispatch and the response strobe come on top of these.
// Reset clears the fill count and the sequencer; the memories need no clear.
// The receiver cannot stall: a result strobes once and is gone.
// ----------------------------------------------------------------------------
`default_nettype none
module peak_table_window_query
   import ptwq_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   output logic             done,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [31:0] req_query_mass,
   input  wire logic [31:0] req_upper_mass,
   input  wire logic [9:0]  req_tolerance_ppm,
   input  wire logic [31:0] req_new_intensity,
   output logic [1:0]       rsp_status,
   output logic [43:0]      rsp_intensity_total,
   output logic [31:0]      rsp_found_mass,
   output logic [31:0]      rsp_found_intensity
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   // one million is 64 * 15625; divide by 15625 through its reciprocal
   localparam logic [13:0] PPM_ODD   = 14'd15625;
   localparam logic [22:0] PPM_RECIP = 23'd4398046;   // floor(2^36 / 15625)

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_WIN   = 4'd3;
   localparam logic [3:0] S_BS_RD = 4'd4;
   localparam logic [3:0] S_BS_CK = 4'd5;
   localparam logic [3:0] S_DISP  = 4'd6;
   localparam logic [3:0] S_WK_RD = 4'd7;
   localparam logic [3:0] S_WK_CK = 4'd8;
   localparam logic [3:0] S_NR_RD = 4'd9;
   localparam logic [3:0] S_NR_CK = 4'd10;
   localparam logic [3:0] S_SH_RD = 4'd11;
   localparam logic [3:0] S_SH_WR = 4'd12;
   localparam logic [3:0] S_ADD_F = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   logic [31:0] mass_mem [TABLE_DEPTH];
   logic [31:0] inten_mem [TABLE_DEPTH];

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]  op_ff, op_in;
   logic [31:0] qm_ff, qm_in, ni_ff, ni_in;
   logic [31:0] lo_ff, lo_in, hi_ff, hi_in, half_ff, half_in;
   logic [41:0] prod_ff, prod_in;   // center * ppm, up to 42 bits
   logic [9:0]  mplier_ff, mplier_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  step_ff, step_in;
   logic [CW-1:0] bl_ff, bl_in, bh_ff, bh_in, k_ff, k_in, idx_ff, idx_in;
   logic [31:0] bm_ff, bm_in, bi_ff, bi_in;   // best or lower neighbour
   logic [43:0] sum_ff, sum_in;
   logic        nsec_ff, nsec_in;             // nearest: second read pending
   logic [1:0]  st_ff, st_in;
   logic [43:0] tot_ff, tot_in;
   logic [31:0] fm_ff, fm_in, fi_ff, fi_in;

   // memory port: one read address, one write per cycle
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_mass_ff, rd_int_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_mass, wr_int;

   logic [CW-1:0] mid;
   logic [58:0]   recip_w;
   logic [36:0]   back_w, rem_w;
   logic [32:0]   wide;
   logic [44:0]   sum_w;
   logic [31:0]   d_up, d_dn, gap_w;

   // ------------------------------------------------------------------
   // Memory: registered read, single write
   always_ff @(posedge clock) begin
      rd_mass_ff <= mass_mem[rd_addr];
      rd_int_ff  <= inten_mem[rd_addr];
      if (wr_en) begin
         mass_mem[wr_addr]  <= wr_mass;
         inten_mem[wr_addr] <= wr_int;
      end
   end

   assign mid = CW'((({1'b0, bl_ff} + {1'b0, bh_ff}) >> 1));

   // ------------------------------------------------------------------
   // Sequencer
   always_comb begin
      state_in = state_ff; count_in = count_ff; op_in = op_ff;
      qm_in = qm_ff; ni_in = ni_ff;
      lo_in = lo_ff; hi_in = hi_ff; half_in = half_ff;
      prod_in = prod_ff; mplier_in = mplier_ff; quo_in = quo_ff;
      step_in = step_ff; bl_in = bl_ff; bh_in = bh_ff; k_in = k_ff; idx_in = idx_ff;
      bm_in = bm_ff; bi_in = bi_ff; sum_in = sum_ff;
      nsec_in = nsec_ff; st_in = st_ff; tot_in = tot_ff; fm_in = fm_ff; fi_in = fi_ff;
      rd_addr = AW'(k_ff); wr_en = 1'b0; wr_addr = AW'(k_ff);
      wr_mass = rd_mass_ff; wr_int = rd_int_ff;
      recip_w = '0; back_w = '0; rem_w = '0;
      wide = '0; sum_w = '0; d_up = '0; d_dn = '0; gap_w = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_opcode; qm_in = req_query_mass;
               ni_in = req_new_intensity;
               prod_in = '0; mplier_in = req_tolerance_ppm; step_in = '0;
               st_in = ST_OK; tot_in = '0; fm_in = '0; fi_in = '0;
               lo_in = req_query_mass; hi_in = req_upper_mass;
               bl_in = '0; bh_in = count_ff;
               if (req_opcode == OP_CLEAR) begin
                  count_in = '0; state_in = S_DONE;
               end else if (req_opcode == OP_ADD || req_opcode == OP_SUM_ABS ||
                            req_opcode == OP_MAX_ABS || req_opcode == OP_NEAR_ABS) begin
                  half_in = req_upper_mass;
                  state_in = S_BS_RD;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         // shift-add multiply, one ppm bit per cycle from the top
         S_MUL: begin
            prod_in = (prod_ff << 1) + (mplier_ff[9] ? {10'd0, qm_ff} : 42'd0);
            mplier_in = mplier_ff << 1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd9) begin
               step_in = '0; quo_in = '0; state_in = S_DIV;
            end
         end
         // divide by one million: estimate by reciprocal, then correct by one
         S_DIV: begin
            if (step_ff == 6'd0) begin
               recip_w = {23'd0, prod_ff[41:6]} * {36'd0, PPM_RECIP};
               quo_in = {9'd0, recip_w[58:36]};
               step_in = 6'd1;
            end else begin
               back_w = {14'd0, quo_ff[22:0]} * {23'd0, PPM_ODD};
               rem_w = {1'b0, prod_ff[41:6]} - back_w;
               if (rem_w >= {23'd0, PPM_ODD}) quo_in = quo_ff + 32'd1;
               state_in = S_WIN;
            end
         end
         // nearest keeps the centre as search key
         S_WIN: begin
            half_in = quo_ff;
            lo_in = (op_ff == OP_NEAR_PPM) ? qm_ff : qm_ff - quo_ff;
            wide = {1'b0, qm_ff} + {1'b0, quo_ff};
            hi_in = wide[32] ? MASS_LIMIT : wide[31:0];
            state_in = S_BS_RD;
         end
         // binary search for first mass >= key
         S_BS_RD: begin
            if (bl_ff < bh_ff) begin
               rd_addr = AW'(mid); state_in = S_BS_CK;
            end else begin
               idx_in = bl_ff; state_in = S_DISP;
            end
         end
         S_BS_CK: begin
            if (rd_mass_ff < lo_ff) bl_in = mid + CW'(1);
            else bh_in = mid;
            state_in = S_BS_RD;
         end
         S_DISP: begin
            k_in = idx_ff; sum_in = '0; nsec_in = 1'b0;
            if (op_ff == OP_ADD) begin
               k_in = count_ff; state_in = S_ADD_F;
               if (idx_ff < count_ff) begin
                  rd_addr = AW'(idx_ff);
               end
            end else if (op_ff == OP_NEAR_ABS || op_ff == OP_NEAR_PPM) begin
               if (count_ff == '0) begin
                  st_in = ST_NONE; state_in = S_DONE;
               end else if (idx_ff >= count_ff) begin
                  k_in = count_ff - CW'(1); state_in = S_NR_RD;
               end else if (idx_ff == '0) begin
                  state_in = S_NR_RD;
               end else begin
                  k_in = idx_ff - CW'(1); nsec_in = 1'b1; state_in = S_NR_RD;
               end
            end else begin
               bi_in = '0; bm_in = '0;
               if (idx_ff >= count_ff) begin
                  st_in = ST_NONE; state_in = S_DONE;
               end else state_in = S_WK_RD;
            end
         end
         // add: entry at idx read back this cycle
         S_ADD_F: begin
            if (idx_ff < count_ff && rd_mass_ff == qm_ff) begin
               wide = {1'b0, rd_int_ff} + {1'b0, ni_ff};
               wr_en = 1'b1; wr_addr = AW'(idx_ff); wr_mass = qm_ff;
               wr_int = wide[32] ? MASS_LIMIT : wide[31:0];
               state_in = S_DONE;
            end else if (count_ff >= DEPTH_C) begin
               st_in = ST_FULL; state_in = S_DONE;
            end else begin
               state_in = S_SH_RD;
            end
         end
         // shift entries up by one, top down
         S_SH_RD: begin
            if (k_ff > idx_ff) begin
               rd_addr = AW'(k_ff - CW'(1)); state_in = S_SH_WR;
            end else begin
               wr_en = 1'b1; wr_addr = AW'(idx_ff); wr_mass = qm_ff; wr_int = ni_ff;
               count_in = count_ff + CW'(1); state_in = S_DONE;
            end
         end
         S_SH_WR: begin
            wr_en = 1'b1; wr_addr = AW'(k_ff);
            k_in = k_ff - CW'(1); state_in = S_SH_RD;
         end
         // walk the window
         S_WK_RD: begin
            if (k_ff < count_ff) begin
               rd_addr = AW'(k_ff); state_in = S_WK_CK;
            end else state_in = S_DONE;
         end
         S_WK_CK: begin
            if (rd_mass_ff > hi_ff) begin
               if (k_ff == idx_ff) st_in = ST_NONE;
               state_in = S_DONE;
            end else begin
               sum_w = {1'b0, sum_ff} + {13'd0, rd_int_ff};
               sum_in = sum_w[44] ? SUM_LIMIT : sum_w[43:0];
               if (k_ff == idx_ff || bi_ff < rd_int_ff) begin
                  bi_in = rd_int_ff; bm_in = rd_mass_ff;
               end
               if (op_ff == OP_SUM_ABS || op_ff == OP_SUM_PPM) tot_in = sum_in;
               else begin
                  tot_in = {12'd0, bi_in}; fm_in = bm_in; fi_in = bi_in;
               end
               k_in = k_ff + CW'(1); state_in = S_WK_RD;
            end
         end
         // nearest: read lower neighbour then upper, or the single candidate
         S_NR_RD: begin
            rd_addr = AW'(k_ff); state_in = S_NR_CK;
         end
         S_NR_CK: begin
            if (nsec_ff) begin
               bm_in = rd_mass_ff; bi_in = rd_int_ff; nsec_in = 1'b0;
               k_in = idx_ff; step_in = 6'd1; state_in = S_NR_RD;
            end else begin
               if (step_ff == 6'd1) begin
                  d_up = rd_mass_ff - qm_ff; d_dn = qm_ff - bm_ff;
                  if (!(d_up < d_dn)) begin
                     bm_in = bm_ff; bi_in = bi_ff; gap_w = d_dn;
                  end else begin
                     bm_in = rd_mass_ff; bi_in = rd_int_ff; gap_w = d_up;
                  end
               end else begin
                  bm_in = rd_mass_ff; bi_in = rd_int_ff;
                  gap_w = (rd_mass_ff >= qm_ff) ? rd_mass_ff - qm_ff : qm_ff - rd_mass_ff;
               end
               if (gap_w <= half_ff) begin
                  tot_in = {12'd0, bi_in}; fm_in = bm_in; fi_in = bi_in;
               end else st_in = ST_NONE;
               state_in = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; step_ff <= '0; nsec_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; nsec_ff <= nsec_in;
         step_ff <= (state_ff == S_DISP) ? 6'd0 : step_in;
      end
      op_ff <= op_in; qm_ff <= qm_in; ni_ff <= ni_in;
      lo_ff <= lo_in; hi_ff <= hi_in; half_ff <= half_in;
      prod_ff <= prod_in; mplier_ff <= mplier_in; quo_ff <= quo_in;
      bl_ff <= bl_in; bh_ff <= bh_in; k_ff <= k_in; idx_ff <= idx_in;
      bm_ff <= bm_in; bi_ff <= bi_in; sum_ff <= sum_in;
      st_ff <= st_in; tot_ff <= tot_in; fm_ff <= fm_in; fi_ff <= fi_in;
   end

   // Drive outputs; any status other than OK forces payload to zero
   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);
   assign rsp_status = st_ff;
   assign rsp_intensity_total = (st_ff == ST_OK) ? tot_ff : 44'd0;
   assign rsp_found_mass      = (st_ff == ST_OK) ? fm_ff : 32'd0;
   assign rsp_found_intensity = (st_ff == ST_OK) ? fi_ff : 32'd0;
endmodule
`default_nettype wire

FILE: test/peak_table_window_query_checker.sv
// ----------------------------------------------------------------------------
// Peak table window query checker
// Watches the request and response channels, keeps its own copy of the peak
// table, predicts one response per accepted request and compares each
// strobed response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module peak_table_window_query_checker
   import ptwq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        done,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_query_mass,
   input  logic [31:0] req_upper_mass,
   input  logic [9:0]  req_tolerance_ppm,
   input  logic [31:0] req_new_intensity,
   input  logic [1:0]  rsp_status,
   input  logic [43:0] rsp_intensity_total,
   input  logic [31:0] rsp_found_mass,
   input  logic [31:0] rsp_found_intensity,
   output int          fail_count,
   output int          pending
);
   localparam int DEPTH = DEFAULT_TABLE_DEPTH;

   typedef struct packed {
      logic [1:0]  status;
      logic [43:0] total;
      logic [31:0] mass;
      logic [31:0] inten;
   } peak_rsp_type;

   logic [31:0]  model_mass [DEPTH];
   logic [31:0]  model_inten [DEPTH];
   int unsigned  model_count;
   peak_rsp_type pending_rsp [$];

   // lowest index whose mass is not below key, or the fill count
   function automatic int unsigned lower_index(logic [31:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = model_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (model_mass[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic logic [31:0] ppm_width(logic [31:0] centre, logic [9:0] ppm);
      logic [63:0] prod;
      prod = {32'd0, centre} * {54'd0, ppm};
      return 32'(prod / {44'd0, PPM_SCALE});
   endfunction

   // update the model table and work out the response of one transaction
   task automatic predict_peak_rsp(input logic [2:0] op, input logic [31:0] qm,
                                   input logic [31:0] um, input logic [9:0] ppm,
                                   input logic [31:0] ni, output peak_rsp_type r);
      int unsigned idx;
      int unsigned k;
      int unsigned sel;
      int unsigned best;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] half;
      logic [31:0] allow;
      logic [31:0] up;
      logic [31:0] dn;
      logic [31:0] delta;
      logic [32:0] wide;
      logic [44:0] acc;
      r = '0;
      if (op == OP_CLEAR) begin
         model_count = 0;
      end else if (op == OP_ADD) begin
         idx = lower_index(qm);
         if (idx < model_count && model_mass[idx] == qm) begin
            wide = {1'b0, model_inten[idx]} + {1'b0, ni};
            model_inten[idx] = wide[32] ? MASS_LIMIT : wide[31:0];
         end else if (model_count >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            for (k = model_count; k > idx; k--) begin
               model_mass[k]  = model_mass[k-1];
               model_inten[k] = model_inten[k-1];
            end
            model_mass[idx]  = qm;
            model_inten[idx] = ni;
            model_count++;
         end
      end else if (op == OP_NEAR_ABS || op == OP_NEAR_PPM) begin
         allow = (op == OP_NEAR_ABS) ? um : ppm_width(qm, ppm);
         if (model_count == 0) begin
            r.status = ST_NONE;
         end else begin
            idx = lower_index(qm);
            if (idx >= model_count) sel = model_count - 1;
            else if (idx == 0) sel = 0;
            else begin
               up  = model_mass[idx] - qm;
               dn  = qm - model_mass[idx-1];
               sel = (up < dn) ? idx : idx - 1;
            end
            delta = (model_mass[sel] >= qm) ? model_mass[sel] - qm : qm - model_mass[sel];
            if (delta <= allow) begin
               r.total = {12'd0, model_inten[sel]};
               r.mass  = model_mass[sel];
               r.inten = model_inten[sel];
            end else begin
               r.status = ST_NONE;
            end
         end
      end else begin
         if (op == OP_SUM_ABS || op == OP_MAX_ABS) begin
            lo = qm;
            hi = um;
         end else begin
            half = ppm_width(qm, ppm);
            wide = {1'b0, qm} + {1'b0, half};
            lo   = qm - half;
            hi   = wide[32] ? MASS_LIMIT : wide[31:0];
         end
         idx = lower_index(lo);
         if (idx >= model_count || model_mass[idx] > hi) begin
            r.status = ST_NONE;
         end else if (op == OP_SUM_ABS || op == OP_SUM_PPM) begin
            acc = '0;
            for (k = idx; k < model_count && model_mass[k] <= hi; k++) begin
               acc = acc + {13'd0, model_inten[k]};
               if (acc > {1'b0, SUM_LIMIT}) acc = {1'b0, SUM_LIMIT};
            end
            r.total = acc[43:0];
         end else begin
            best = idx;
            for (k = idx; k < model_count && model_mass[k] <= hi; k++)
               if (model_inten[best] < model_inten[k]) best = k;
            r.total = {12'd0, model_inten[best]};
            r.mass  = model_mass[best];
            r.inten = model_inten[best];
         end
      end
   endtask

   assign pending = pending_rsp.size();

   // compare strobed responses, then predict for the accepted request
   always @(posedge clock) begin
      peak_rsp_type exp_rsp;
      peak_rsp_type new_rsp;
      if (reset) begin
         model_count = 0;
         pending_rsp.delete();
         fail_count  = 0;
      end else begin
         if (done) begin
            if (pending_rsp.size() == 0) begin
               $error("response strobed with no request outstanding");
               fail_count++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $error("status: expected %0d actual %0d", exp_rsp.status, rsp_status);
                  fail_count++;
               end
               if (rsp_intensity_total !== exp_rsp.total) begin
                  $error("intensity_total: expected %0h actual %0h",
                         exp_rsp.total, rsp_intensity_total);
                  fail_count++;
               end
               if (rsp_found_mass !== exp_rsp.mass) begin
                  $error("found_mass: expected %0h actual %0h", exp_rsp.mass, rsp_found_mass);
                  fail_count++;
               end
               if (rsp_found_intensity !== exp_rsp.inten) begin
                  $error("found_intensity: expected %0h actual %0h",
                         exp_rsp.inten, rsp_found_intensity);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            predict_peak_rsp(req_opcode, req_query_mass, req_upper_mass,
                             req_tolerance_ppm, req_new_intensity, new_rsp);
            pending_rsp = {pending_rsp, new_rsp};
         end
      end
   end
endmodule

FILE: test/peak_table_window_query_tb.sv
// ----------------------------------------------------------------------------
// Peak table window query testbench
// Drives directed corner transactions and a long random mix of clears, adds
// and window queries in bursts with random gaps; the checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module peak_table_window_query_tb;
   import ptwq_pkg::*;

   localparam int RANDOM_ITEMS = 1980;
   localparam int CYCLE_LIMIT  = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        done;
   logic [2:0]  req_opcode = OP_CLEAR;
   logic [31:0] req_query_mass = '0;
   logic [31:0] req_upper_mass = '0;
   logic [9:0]  req_tolerance_ppm = '0;
   logic [31:0] req_new_intensity = '0;
   logic [1:0]  rsp_status;
   logic [43:0] rsp_intensity_total;
   logic [31:0] rsp_found_mass;
   logic [31:0] rsp_found_intensity;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          burst_left = 0;
   logic [31:0] pool_base;
   logic [31:0] pool_step;

   always #10 clock = ~clock;

   peak_table_window_query u_dut (
      .clock, .reset, .start, .busy, .done,
      .req_opcode, .req_query_mass, .req_upper_mass, .req_tolerance_ppm,
      .req_new_intensity,
      .rsp_status, .rsp_intensity_total, .rsp_found_mass, .rsp_found_intensity
   );

   peak_table_window_query_checker u_checker (
      .clock, .reset, .start, .busy, .done,
      .req_opcode, .req_query_mass, .req_upper_mass, .req_tolerance_ppm,
      .req_new_intensity,
      .rsp_status, .rsp_intensity_total, .rsp_found_mass, .rsp_found_intensity,
      .fail_count, .pending
   );

   // abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // present one transaction and hold it until accepted; gaps fall between bursts
   task automatic send_txn(input logic [2:0] op, input logic [31:0] qm,
                           input logic [31:0] um, input logic [9:0] ppm,
                           input logic [31:0] ni);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start             = 1'b1;
      req_opcode        = op;
      req_query_mass    = qm;
      req_upper_mass    = um;
      req_tolerance_ppm = ppm;
      req_new_intensity = ni;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [31:0] pick_mass();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return MASS_LIMIT;
         2:       return $urandom;
         default: return pool_base + pool_step * $urandom_range(0, 40);
      endcase
   endfunction

   function automatic logic [31:0] pick_intensity();
      case ($urandom_range(0, 7))
         0:       return MASS_LIMIT;
         1:       return 32'd0;
         2:       return $urandom_range(1, 4);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] m;
      logic [31:0] span;
      int          n;
      int          op_sel;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners: empty table, saturation, ties, window edges
      send_txn(OP_CLEAR, 0, 0, 0, 0);
      send_txn(OP_SUM_ABS, 0, MASS_LIMIT, 0, 0);
      send_txn(OP_MAX_PPM, 32'd5000, 0, 10'd1023, 0);
      send_txn(OP_NEAR_ABS, 32'd100, MASS_LIMIT, 0, 0);
      send_txn(OP_ADD, 32'd0, 0, 0, 32'd7);
      send_txn(OP_ADD, MASS_LIMIT, 0, 0, MASS_LIMIT);
      send_txn(OP_ADD, MASS_LIMIT, 0, 0, 32'd5);
      send_txn(OP_ADD, 32'd100, 0, 0, 32'd50);
      send_txn(OP_ADD, 32'd200, 0, 0, 32'd50);
      send_txn(OP_SUM_ABS, 0, MASS_LIMIT, 0, 0);
      send_txn(OP_SUM_ABS, 32'd300, 32'd150, 0, 0);
      send_txn(OP_SUM_ABS, 32'd101, 32'd199, 0, 0);
      send_txn(OP_MAX_ABS, 32'd50, 32'd250, 0, 0);
      send_txn(OP_SUM_PPM, MASS_LIMIT, 0, 10'd1023, 0);
      send_txn(OP_MAX_PPM, 32'd150, 0, 10'd1023, 0);
      send_txn(OP_NEAR_ABS, 32'd150, 32'd50, 0, 0);
      send_txn(OP_NEAR_ABS, 32'd150, 32'd49, 0, 0);
      send_txn(OP_NEAR_PPM, 32'hF000_0000, 0, 10'd1000, 0);
      send_txn(OP_NEAR_PPM, 32'd1000, 0, 10'd0, 0);
      send_txn(OP_NEAR_ABS, 32'd1000, 32'd0, 0, 0);

      // random mix around a small mass pool so windows hit often
      pool_base = $urandom;
      pool_step = $urandom_range(1, 2000);
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         op_sel = $urandom_range(0, 99);
         m      = pick_mass();
         span   = ($urandom_range(0, 4) == 0) ? $urandom : pool_step * $urandom_range(0, 12);
         if (op_sel < 2) begin
            send_txn(OP_CLEAR, $urandom, $urandom, 10'($urandom), $urandom);
            pool_base = $urandom;
            pool_step = $urandom_range(1, 2000);
         end else if (op_sel < 42) begin
            send_txn(OP_ADD, m, $urandom, 10'($urandom), pick_intensity());
         end else begin
            send_txn(3'($urandom_range(2, 7)), m,
                     ($urandom_range(0, 5) == 0) ? m - span : m + span,
                     10'($urandom_range(0, 1023)), $urandom);
         end
      end

      // drain the outstanding responses
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

FILE: peak_table_window_query.f
rtl/ptwq_pkg.sv
rtl/peak_table_window_query.sv
test/peak_table_window_query_checker.sv
test/peak_table_window_query_tb.sv
